/* design/binary_morphology_3x3_stream_top_defines.svh */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_3X3_STREAM_TOP_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_STREAM_TOP_DEFINES_SVH

// Same-cycle implication.
`define BM3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BM3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bm3_pkg.sv */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: package
// Field widths, register codes, queue item types and the kernel functions.
// ----------------------------------------------------------------------------
package bm3_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 11;
	localparam int MODE_W      = 2;
	localparam int KERNEL_SIZE = 3;
	localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
	localparam int TAP_CENTER  = (TAPS - 1) / 2;
	localparam int ROW_W       = 11;
	localparam int OUT_ROW_W   = 10;
	localparam int IDX_W       = 2;

	localparam logic [CFG_W-1:0] MAX_HEIGHT = 11'd1024;
	localparam logic [ROW_W-1:0] ROW_MAX    = 11'd2047;

	localparam logic [PIX_W-1:0] PIX_OBJECT     = 8'd0;
	localparam logic [PIX_W-1:0] PIX_BACKGROUND = 8'd255;

	localparam logic [MODE_W-1:0] MODE_RESET   = 2'd0;
	localparam logic [TAPS-1:0]   MASK_RESET   = 9'd186;
	localparam logic [CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [CFG_W-1:0]  HEIGHT_RESET = 11'd1024;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_ERODE   = 2'd0,
		MODE_DILATE  = 2'd1,
		MODE_CONTOUR = 2'd2
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_MASK   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TAPS-1:0]   kernel_mask;
		logic [CFG_W-1:0]  image_width;
		logic [CFG_W-1:0]  image_height;
	} cfg_t;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} border_t;

	typedef struct packed {
		logic    newbit;
		logic    emit;
		logic    last;
		border_t border;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

	function automatic logic [TAPS-1:0] inside_taps(border_t b);
		logic [TAPS-1:0] v;
		int r;
		int c;
		for (int i = 0; i < TAPS; i++) begin
			r = i / KERNEL_SIZE;
			c = i % KERNEL_SIZE;
			v[i] = 1'b1;
			if (r == 0 && !b.top_ok) v[i] = 1'b0;
			if (r == KERNEL_SIZE - 1 && !b.bot_ok) v[i] = 1'b0;
			if (c == 0 && !b.left_ok) v[i] = 1'b0;
			if (c == KERNEL_SIZE - 1 && !b.right_ok) v[i] = 1'b0;
		end
		return v;
	endfunction

	function automatic logic erode_at(logic [TAPS-1:0] win, logic [TAPS-1:0] mask,
		logic [TAPS-1:0] ins);
		return win[TAP_CENTER] && (&(~mask | (ins & win)));
	endfunction

	function automatic logic dilate_at(logic [TAPS-1:0] win, logic [TAPS-1:0] mask,
		logic [TAPS-1:0] ins);
		logic [TAPS-1:0] mm;
		for (int i = 0; i < TAPS; i++) begin
			mm[i] = mask[TAPS-1-i];
		end
		return |(mm & ins & win);
	endfunction

endpackage

/* design/bm3_stream_if.sv */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: channel interfaces
// Valid/ready channels for source pixels and for result pixels.
// ----------------------------------------------------------------------------
interface bm3_in_if import bm3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output kind, output pixel, input ready);
	modport sink (input valid, input kind, input pixel, output ready);
endinterface

interface bm3_out_if import bm3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             last_of_frame;

	modport source (output valid, output out_pixel, output last_of_frame, input ready);
	modport sink (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

/* design/bm3_front.sv */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: front end
// Accepts source transactions, tracks input and output positions and tags
// each item with its line store column, object bit and image border flags.
// ----------------------------------------------------------------------------
module bm3_front import bm3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bm3_in_if.sink                         pixels,
	input  cfg_t                           cfg,
	input  logic                           restart,
	output logic                           push_valid,
	input  logic                           push_ready,
	output logic [$clog2(MAX_WIDTH)-1:0]   push_x,
	output item_t                          push_item
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int WCW = (WW > CFG_W) ? WW : CFG_W;

	logic [CW-1:0]        in_col_q;
	logic [ROW_W-1:0]     in_row_q;
	logic [CW-1:0]        out_col_q;
	logic [OUT_ROW_W-1:0] out_row_q;

	logic                 acc;
	logic [WCW-1:0]       wreg_ext;
	logic [WW-1:0]        w_eff;
	logic [CFG_W-1:0]     h_eff;
	logic [WW-1:0]        x_ext;
	logic [CW-1:0]        x;
	logic                 row_end;
	logic                 col_last;
	logic                 row_last;
	item_t                item;

	assign pixels.ready = push_ready;
	assign push_valid   = pixels.valid;
	assign acc          = pixels.valid && push_ready;

	always_comb begin
		wreg_ext = WCW'(cfg.image_width);
		if (cfg.image_width == '0) begin
			w_eff = WW'(1);
		end else if (wreg_ext > WCW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(wreg_ext);
		end

		if (cfg.image_height == '0) begin
			h_eff = CFG_W'(1);
		end else if (cfg.image_height > MAX_HEIGHT) begin
			h_eff = MAX_HEIGHT;
		end else begin
			h_eff = cfg.image_height;
		end

		x     = (WW'(in_col_q) >= w_eff) ? '0 : in_col_q;
		x_ext = WW'(x);
		row_end = (x_ext + WW'(1)) >= w_eff;

		col_last = WW'(out_col_q) == (w_eff - WW'(1));
		row_last = CFG_W'(out_row_q) == (h_eff - CFG_W'(1));

		item.newbit = !pixels.kind && (pixels.pixel == '0) && (in_row_q < ROW_W'(h_eff));
		item.emit   = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && x != '0);
		item.last   = col_last && row_last;
		item.border.top_ok   = out_row_q != '0;
		item.border.bot_ok   = !row_last;
		item.border.left_ok  = out_col_q != '0;
		item.border.right_ok = !col_last;
	end

	assign push_x    = x;
	assign push_item = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (item.emit && item.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (row_end) begin
					in_col_q <= '0;
					if (in_row_q < ROW_MAX) in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= CW'(x_ext + WW'(1));
				end
				if (item.emit) begin
					if (col_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OUT_ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

endmodule

/* design/bm3_queue.sv */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bm3_queue import bm3_pkg::*; #(
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [DW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0]     mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* design/bm3_back.sv */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: back end
// Line store read-modify-write, 3x3 window shift, kernel evaluation and the
// result output register.
// ----------------------------------------------------------------------------
`include "binary_morphology_3x3_stream_top_defines.svh"

module bm3_back import bm3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         head_valid,
	output logic                         head_ready,
	input  logic [$clog2(MAX_WIDTH)-1:0] head_x,
	input  item_t                        head_item,
	bm3_out_if.source                    results
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic upper_mem [MAX_WIDTH];
	logic lower_mem [MAX_WIDTH];

	logic             rd_up_q;
	logic             rd_lo_q;
	logic             s2_valid_q;
	logic [CW-1:0]    x_s2;
	item_t            item_s2;
	logic             fwd_s2;
	logic             fwd_up_s2;
	logic             fwd_lo_s2;
	logic [TAPS-1:0]  window_q;
	logic             ov_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_last_q;

	logic             s2_go;
	logic             s2_load;
	logic             rd_en;
	logic             up_cur;
	logic             lo_cur;
	logic [2:0]       col;
	logic [TAPS-1:0]  nb;
	logic [TAPS-1:0]  ins;
	logic             er;
	logic             di;
	logic             obj;

	assign s2_go      = s2_valid_q && (!item_s2.emit || !ov_q || results.ready);
	assign s2_load    = !s2_valid_q || s2_go;
	assign head_ready = s2_load;
	assign rd_en      = head_valid && s2_load;

	assign up_cur = fwd_s2 ? fwd_up_s2 : rd_up_q;
	assign lo_cur = fwd_s2 ? fwd_lo_s2 : rd_lo_q;
	assign col    = {item_s2.newbit, lo_cur, up_cur};

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			nb[r*KERNEL_SIZE]     = window_q[r*KERNEL_SIZE + 1];
			nb[r*KERNEL_SIZE + 1] = window_q[r*KERNEL_SIZE + 2];
			nb[r*KERNEL_SIZE + 2] = col[r];
		end
		ins = inside_taps(item_s2.border);
		er  = erode_at(nb, cfg.kernel_mask, ins);
		di  = dilate_at(nb, cfg.kernel_mask, ins);
		case (cfg.mode)
			MODE_DILATE:  obj = di;
			MODE_CONTOUR: obj = nb[TAP_CENTER] && !er;
			default:      obj = er;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			upper_mem[x_s2] <= lo_cur;
			lower_mem[x_s2] <= item_s2.newbit;
		end
		if (rd_en) begin
			rd_up_q <= upper_mem[head_x];
			rd_lo_q <= lower_mem[head_x];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			x_s2      <= head_x;
			item_s2   <= head_item;
			fwd_up_s2 <= lo_cur;
			fwd_lo_s2 <= item_s2.newbit;
		end
		if (s2_go && item_s2.emit) begin
			out_pixel_q <= obj ? PIX_OBJECT : PIX_BACKGROUND;
			out_last_q  <= item_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			fwd_s2     <= 1'b0;
			window_q   <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (s2_load) s2_valid_q <= head_valid;
			if (rd_en) begin
				fwd_s2 <= s2_go && (x_s2 == head_x);
			end else if (s2_go) begin
				fwd_s2 <= 1'b0;
			end
			if (s2_go) window_q <= nb;
			if (s2_go && item_s2.emit) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign results.valid         = ov_q;
	assign results.out_pixel     = out_pixel_q;
	assign results.last_of_frame = out_last_q;

	`BM3_ASSERT_NOW(a_fwd_needs_item, fwd_s2, s2_valid_q, "forwarded data without an item")
	`BM3_ASSERT_NEXT(a_emit_fills_out, s2_go && item_s2.emit, ov_q, "result was lost")
	`BM3_ASSERT_NEXT(a_window_shift, s2_go, window_q[7:6] == $past(window_q[8:7]), "window did not shift")

endmodule

/* design/binary_morphology_3x3_stream_top.sv */
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: top level
// A result reaches the output register once the transaction completing its
// window has passed the queue and read stage, image_width + 1 transactions
// after its own pixel. One transaction per cycle unless results stall.
// Reset clears counters, window, queue and registers; line stores are kept.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_stream_top import bm3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	bm3_in_if.sink           pixels,
	bm3_out_if.source        results,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = CW + ITEM_W;

	cfg_t          cfg_q;
	logic          restart;
	logic          push_valid;
	logic          push_ready;
	logic [CW-1:0] push_x;
	item_t         push_item;
	logic          head_valid;
	logic          head_ready;
	logic [QW-1:0] head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_RESET;
			cfg_q.kernel_mask  <= MASK_RESET;
			cfg_q.image_width  <= WIDTH_RESET;
			cfg_q.image_height <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode         <= cfg_wdata[MODE_W-1:0];
				REG_MASK:   cfg_q.kernel_mask  <= cfg_wdata[TAPS-1:0];
				REG_WIDTH:  cfg_q.image_width  <= cfg_wdata;
				REG_HEIGHT: cfg_q.image_height <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	bm3_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.cfg        (cfg_q),
		.restart    (restart),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_x     (push_x),
		.push_item  (push_item)
	);

	bm3_queue #(
		.DW (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_x, push_item}),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head_data)
	);

	bm3_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head_x     (head_data[QW-1:ITEM_W]),
		.head_item  (item_t'(head_data[ITEM_W-1:0])),
		.results    (results)
	);

endmodule

/* bench/binary_morphology_3x3_stream_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary morphology 3x3 stream: self-checking bench
// Streams binary frames through erode, dilate and contour settings, tracks
// the line stores and window alongside the block to work out each result
// pixel and its end-of-frame flag, and compares every result transaction.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_stream_top_test;
	import bm3_pkg::*;

	localparam int LINE_MAX     = 1024;
	localparam int SETTLE       = 8;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             last_of_frame;
	} morph_out_t;

	class window_tracker;
		logic [MODE_W-1:0] mode;
		logic [TAPS-1:0]   kernel;
		logic [CFG_W-1:0]  width_reg;
		logic [CFG_W-1:0]  height_reg;
		bit                upper_row [LINE_MAX];
		bit                lower_row [LINE_MAX];
		logic [TAPS-1:0]   window;
		int unsigned       column;
		int unsigned       row;
		int unsigned       out_count;
		morph_out_t        due [$];
		int unsigned       mismatches;
		int unsigned       results_seen;
		int unsigned       frames_seen;

		function new();
			mode = MODE_RESET;
			kernel = MASK_RESET;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_row[i]) begin
				upper_row[i] = 1'b0;
				lower_row[i] = 1'b0;
			end
			window = '0;
			restart();
		endfunction

		function void restart();
			column = 0;
			row = 0;
			out_count = 0;
		endfunction

		function int unsigned cur_width();
			if (width_reg == 0) return 1;
			if (width_reg > LINE_MAX) return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned cur_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_MODE: mode = v[MODE_W-1:0];
				REG_MASK: kernel = v[TAPS-1:0];
				REG_WIDTH: begin
					width_reg = v;
					restart();
				end
				REG_HEIGHT: begin
					height_reg = v;
					restart();
				end
				default: ;
			endcase
		endfunction

		function bit in_bounds(int r, int c, int wr, int wc, int w, int h);
			int rr;
			int cc;
			rr = r + wr - 1;
			cc = c + wc - 1;
			return rr >= 0 && rr < h && cc >= 0 && cc < w;
		endfunction

		function bit win_bit(int wr, int wc);
			return window[wr * KERNEL_SIZE + wc];
		endfunction

		function bit eroded(int r, int c, int w, int h);
			if (!win_bit(1, 1)) return 1'b0;
			for (int a = 0; a < KERNEL_SIZE; a++)
				for (int b = 0; b < KERNEL_SIZE; b++) begin
					if (!kernel[a * KERNEL_SIZE + b]) continue;
					if (!in_bounds(r, c, a, b, w, h) || !win_bit(a, b)) return 1'b0;
				end
			return 1'b1;
		endfunction

		// The kernel is mirrored: tap (a, b) looks at window cell (2 - a, 2 - b).
		function bit dilated(int r, int c, int w, int h);
			for (int a = 0; a < KERNEL_SIZE; a++)
				for (int b = 0; b < KERNEL_SIZE; b++) begin
					if (!kernel[a * KERNEL_SIZE + b]) continue;
					if (in_bounds(r, c, 2 - a, 2 - b, w, h) && win_bit(2 - a, 2 - b))
						return 1'b1;
				end
			return 1'b0;
		endfunction

		function void take_pixel(logic kind, logic [PIX_W-1:0] pix);
			int unsigned     w;
			int unsigned     h;
			int unsigned     total;
			int unsigned     x;
			int unsigned     oc;
			bit              nb;
			bit              up;
			bit              lo;
			bit              emit;
			bit              obj;
			logic [2:0]      col;
			logic [TAPS-1:0] nw;
			morph_out_t      res;
			w = cur_width();
			h = cur_height();
			total = w * h;
			x = column;
			if (x >= w) x = 0;
			nb = (kind == 1'b0 && pix == '0 && row < h);
			up = upper_row[x];
			lo = lower_row[x];
			upper_row[x] = lo;
			lower_row[x] = nb;
			col = {nb, lo, up};
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				nw[r * 3] = window[r * 3 + 1];
				nw[r * 3 + 1] = window[r * 3 + 2];
				nw[r * 3 + 2] = col[r];
			end
			window = nw;
			emit = (row >= 2) || (row == 1 && x >= 1);
			if (x + 1 >= w) begin
				column = 0;
				if (row < ROW_MAX) row++;
			end else begin
				column = x + 1;
			end
			if (!emit) return;
			oc = out_count;
			if (oc >= total) oc = total - 1;
			if (mode == MODE_DILATE)
				obj = dilated(oc / w, oc % w, w, h);
			else if (mode == MODE_CONTOUR)
				obj = win_bit(1, 1) && !eroded(oc / w, oc % w, w, h);
			else
				obj = eroded(oc / w, oc % w, w, h);
			res.out_pixel = obj ? PIX_OBJECT : PIX_BACKGROUND;
			res.last_of_frame = (oc + 1 >= total);
			due.push_back(res);
			if (res.last_of_frame) restart();
			else out_count = oc + 1;
		endfunction

		function void compare_pixel(logic [PIX_W-1:0] px, logic lf);
			morph_out_t want;
			results_seen++;
			if (lf === 1'b1) frames_seen++;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d arrived with nothing outstanding: pixel %0d last %0b",
						results_seen, px, lf);
				return;
			end
			want = due.pop_front();
			if (px !== want.out_pixel || lf !== want.last_of_frame) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d: want pixel %0d last %0b, got pixel %0d last %0b",
						results_seen, want.out_pixel, want.last_of_frame, px, lf);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	bm3_in_if  pix_if ();
	bm3_out_if res_if ();

	window_tracker tracker = new();

	int unsigned items_sent;
	int unsigned cfg_writes;
	int          send_idle_pct;
	int          ready_stall_pct;

	binary_morphology_3x3_stream_top #(
		.MAX_WIDTH(LINE_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_if),
		.results(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_if.valid !== 1'b0 && res_if.ready === 1'b1)
				tracker.compare_pixel(res_if.out_pixel, res_if.last_of_frame);
			res_if.ready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	task automatic set_pace(input int phase);
		case (phase)
			1: begin
				send_idle_pct = 88;
				ready_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				ready_stall_pct = 88;
			end
			3: begin
				send_idle_pct = 16;
				ready_stall_pct = 16;
			end
			default: begin
				send_idle_pct = 0;
				ready_stall_pct = 0;
			end
		endcase
	endtask

	task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
		if ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pix_if.valid <= 1'b1;
		pix_if.kind <= kind;
		pix_if.pixel <= pix;
		@(posedge clk);
		while (pix_if.ready !== 1'b1) @(posedge clk);
		tracker.take_pixel(kind, pix);
		items_sent++;
	endtask

	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		tracker.set_reg(idx, v);
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A full frame is width * height pixels plus width + 1 flush slots.
	task automatic send_frame(input int dens, input int cap, input bit noise);
		int total;
		int n;
		total = tracker.cur_width() * tracker.cur_height();
		n = total + tracker.cur_width() + 1;
		if (cap < n) n = cap;
		for (int i = 0; i < n; i++) begin
			if (noise)
				send_item(1'($urandom_range(1)), PIX_W'($urandom));
			else if (i < total && $urandom_range(99) < 3)
				send_item(1'b1, PIX_W'($urandom));
			else if (i < total)
				send_item(1'b0, ($urandom_range(99) < dens) ? PIX_OBJECT :
					PIX_W'($urandom_range(1, 255)));
			else
				send_item($urandom_range(99) < 75,
					($urandom_range(3) == 0) ? PIX_OBJECT : PIX_W'($urandom));
		end
	endtask

	task automatic shuffle_settings(input bit resize);
		int               w;
		int               h;
		logic [CFG_W-1:0] word;
		if ($urandom_range(99) < 60) begin
			word = CFG_W'($urandom);
			word[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
			write_reg(REG_MODE, word);
		end
		if ($urandom_range(99) < 60) begin
			word = CFG_W'($urandom);
			case ($urandom_range(9))
				0: word[TAPS-1:0] = '0;
				1: word[TAPS-1:0] = '1;
				2: word[TAPS-1:0] = MASK_RESET;
				default: ;
			endcase
			write_reg(REG_MASK, word);
		end
		if (resize || $urandom_range(99) < 50) begin
			case ($urandom_range(19))
				0: w = 0;
				1, 2: w = $urandom_range(7, 24);
				default: w = $urandom_range(1, 6);
			endcase
			if (w > 6) h = $urandom_range(1, 3);
			else if ($urandom_range(9) == 0) h = 0;
			else h = $urandom_range(1, 6);
			if ($urandom_range(1)) begin
				write_reg(REG_WIDTH, CFG_W'(w));
				write_reg(REG_HEIGHT, CFG_W'(h));
			end else begin
				write_reg(REG_HEIGHT, CFG_W'(h));
				write_reg(REG_WIDTH, CFG_W'(w));
			end
		end
	endtask

	initial begin
		int unsigned base;
		int          seg;
		int          pick;
		bit          resize;
		arst_n <= 1'b0;
		pix_if.valid <= 1'b0;
		pix_if.kind <= 1'b0;
		pix_if.pixel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		items_sent = 0;
		cfg_writes = 0;
		set_pace(0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Solid 3x3 block under a full kernel: only the center survives erosion.
		write_reg(REG_MODE, CFG_W'(MODE_ERODE));
		write_reg(REG_MASK, 11'h1ff);
		write_reg(REG_WIDTH, 11'd3);
		write_reg(REG_HEIGHT, 11'd3);
		repeat (9) send_item(1'b0, PIX_OBJECT);
		send_item(1'b1, PIX_BACKGROUND);
		send_item(1'b0, PIX_OBJECT);
		send_item(1'b1, PIX_OBJECT);
		send_item(1'b0, 8'h7f);
		wait_idle();

		// Single corner tap checks the kernel mirroring of dilation.
		write_reg(REG_MODE, CFG_W'(MODE_DILATE));
		write_reg(REG_MASK, 11'h001);
		write_reg(REG_WIDTH, 11'd2);
		write_reg(REG_HEIGHT, 11'd2);
		send_item(1'b0, PIX_BACKGROUND);
		send_item(1'b0, 8'h80);
		send_item(1'b0, 8'h01);
		send_item(1'b0, PIX_OBJECT);
		repeat (3) send_item(1'b1, PIX_OBJECT);
		wait_idle();

		// One-pixel-wide contour with a flush slot inside the frame.
		write_reg(REG_MODE, CFG_W'(MODE_CONTOUR));
		write_reg(REG_MASK, CFG_W'(MASK_RESET));
		write_reg(REG_WIDTH, 11'd1);
		write_reg(REG_HEIGHT, 11'd2);
		send_item(1'b1, PIX_OBJECT);
		send_item(1'b0, PIX_OBJECT);
		send_item(1'b1, PIX_OBJECT);
		send_item(1'b1, 8'h55);
		wait_idle();

		// Widest line, clamped from an oversized register value.
		set_pace(1);
		write_reg(REG_MODE, CFG_W'(MODE_DILATE));
		write_reg(REG_MASK, CFG_W'($urandom));
		write_reg(REG_WIDTH, 11'd1024);
		write_reg(REG_HEIGHT, 11'd2);
		write_reg(REG_WIDTH, 11'h7ff);
		send_frame(60, 1040, 1'b0);
		wait_idle();

		// Tallest frame, one pixel wide, with zero and oversized register values.
		set_pace(2);
		write_reg(REG_MODE, CFG_W'(MODE_CONTOUR));
		write_reg(REG_MASK, 11'h1ff);
		write_reg(REG_WIDTH, 11'd0);
		write_reg(REG_HEIGHT, 11'd1024);
		write_reg(REG_HEIGHT, 11'h7ff);
		send_frame(70, 1 << 20, 1'b0);

		base = items_sent;
		seg = 0;
		resize = 1'b1;
		while (items_sent - base < RANDOM_ITEMS) begin
			wait_idle();
			set_pace((seg / 3) % 4);
			shuffle_settings(resize);
			resize = 1'b0;
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame($urandom_range(30, 95), 1 << 20, 1'b0);
			end else if (pick < 85) begin
				send_frame($urandom_range(30, 95),
					$urandom_range(1, tracker.cur_width() * tracker.cur_height()
						+ tracker.cur_width()), 1'b0);
				resize = 1'b1;
			end else begin
				send_frame(0, 1 << 20, 1'b1);
			end
			seg++;
		end
		wait_idle();

		$display("Sent %0d input transactions, checked %0d result transactions in %0d frames.",
			items_sent, tracker.results_seen, tracker.frames_seen);
		$display("Erode, dilate, contour and the spare mode over %0d register writes, %0d mismatches.",
			cfg_writes, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
